// File: rtl/bwm_pkg.sv
// Shared widths, constants, weight tables and beat types for the wheel mixer.
package bwm_pkg;

    // Sensor array and port widths
    localparam int SENSOR_COUNT = 8;
    localparam int PAIR_COUNT   = SENSOR_COUNT / 2;
    localparam int SENSOR_W     = 12;
    localparam int CMD_W        = 11;
    localparam int SPEED_W      = 11;
    localparam int LIMIT_W      = 10;
    localparam int BIAS_W       = 10;
    localparam int THRESH_W     = 15;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;

    // Internal datapath widths
    localparam int SUM_W        = 21;   // weighted sum, signed
    localparam int ABS_W        = 20;   // magnitude of weighted sum
    localparam int PAIR_TOT_W   = SENSOR_W + 1;
    localparam int TOTAL_W      = 15;
    localparam int PROD_W       = 24;   // command times peak, signed
    localparam int ADJ_W        = 12;   // slowed command, signed
    localparam int QUO_W        = 11;   // obstacle quotient magnitude
    localparam int MIX_W        = 14;   // command + obstacle term + bias
    localparam int WHEELS       = 2;    // lane 0 left, lane 1 right

    // Divide by 350 as multiply by ceil(2^28 / 350), exact for magnitudes below 2^20
    localparam int RECIP_W      = 20;
    localparam int RECIP_SHIFT  = 28;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(766959);
    localparam int QUO_MAX      = 1989;

    // Slow-down divides by 8192
    localparam int SLOW_SHIFT   = 13;
    localparam int SLOW_ROUND   = (1 << SLOW_SHIFT) - 1;

    // Register reset values
    localparam logic        [LIMIT_W-1:0]  SPEED_LIMIT_RST = LIMIT_W'(800);
    localparam logic signed [BIAS_W-1:0]   LEFT_BIAS_RST   = BIAS_W'(66);
    localparam logic signed [BIAS_W-1:0]   RIGHT_BIAS_RST  = BIAS_W'(72);
    localparam logic        [THRESH_W-1:0] ACT_THRESH_RST  = THRESH_W'(2800);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_LEFT_BIAS   = 2'd1,
        CFG_RIGHT_BIAS  = 2'd2,
        CFG_ACT_THRESH  = 2'd3
    } t_cfg_idx;

    typedef logic signed [7:0] t_weight;

    localparam t_weight W_RIGHT [SENSOR_COUNT] = '{17, 29, 34, 10, 8, -38, -56, -76};
    localparam t_weight W_LEFT  [SENSOR_COUNT] = '{-72, -58, -36, 8, 10, 36, 28, 18};

    typedef logic [SENSOR_COUNT-1:0][SENSOR_W-1:0] t_sensor_vec;

    typedef struct packed {
        logic        [LIMIT_W-1:0]  speed_limit;
        logic signed [BIAS_W-1:0]   left_bias;
        logic signed [BIAS_W-1:0]   right_bias;
        logic        [THRESH_W-1:0] activity_threshold;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic signed [SUM_W-1:0]   sum_l;
        logic signed [SUM_W-1:0]   sum_r;
        logic        [TOTAL_W-1:0] total;
        logic        [SENSOR_W-1:0] peak;
        logic signed [CMD_W-1:0]   cmd_l;
        logic signed [CMD_W-1:0]   cmd_r;
    } t_sum_beat;

    typedef struct packed {
        logic                    valid;
        logic signed [MIX_W-1:0] mix_l;
        logic signed [MIX_W-1:0] mix_r;
    } t_mix_beat;

    // One reading times its fixed weight, at full sum width
    function automatic logic signed [SUM_W-1:0] weight_term(
        input logic [SENSOR_W-1:0] s,
        input t_weight             w
    );
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] wx;
        sx = SUM_W'(s);
        wx = w;
        return sx * wx;
    endfunction

endpackage

// File: rtl/braitenberg_wheel_mixer_top.sv
// Top level of the wheel mixer: config registers and the six-stage datapath.
//
// Use:
//   Input channel: drive the eight proximity readings and both wheel commands
//   with start high; a beat is taken at each rising edge where start is high
//   and busy is low. busy stays low, so a new beat may enter every cycle.
//   Result channel: o_valid marks one cycle in which o_left_speed and
//   o_right_speed hold a result; the receiver must take it in that cycle.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data
//   (0 speed limit, 1 left bias, 2 right bias, 3 activity threshold).
//   o_cfg_ready is always high. Write only while no beat is in flight.
// Timing:
//   The accepted beat passes through six register stages (pair terms,
//   reduction, magnitude and slow product, reciprocal divide, mix,
//   saturation), none holding state across beats, so throughput is one
//   beat per cycle with no stalls.
// Reset:
//   Synchronous, active low; clears all stage valid bits and loads the
//   register defaults (800, 66, 72, 2800). The receiver cannot stall.
module braitenberg_wheel_mixer_top
    import bwm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    // input beat
    input  logic                      start,
    output logic                      busy,
    input  logic [SENSOR_W-1:0]       i_sensor_0,
    input  logic [SENSOR_W-1:0]       i_sensor_1,
    input  logic [SENSOR_W-1:0]       i_sensor_2,
    input  logic [SENSOR_W-1:0]       i_sensor_3,
    input  logic [SENSOR_W-1:0]       i_sensor_4,
    input  logic [SENSOR_W-1:0]       i_sensor_5,
    input  logic [SENSOR_W-1:0]       i_sensor_6,
    input  logic [SENSOR_W-1:0]       i_sensor_7,
    input  logic signed [CMD_W-1:0]   i_left_command,
    input  logic signed [CMD_W-1:0]   i_right_command,

    // result beat
    output logic                      o_valid,
    output logic signed [SPEED_W-1:0] o_left_speed,
    output logic signed [SPEED_W-1:0] o_right_speed,

    // config writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg        cfg;
    t_sensor_vec sensor_vec;
    t_sum_beat   sum_beat;
    t_mix_beat   mix_beat;
    logic        in_accept;

    // fully pipelined: never holds off the source
    assign busy      = 1'b0;
    assign in_accept = start && !busy;

    assign sensor_vec[0] = i_sensor_0;
    assign sensor_vec[1] = i_sensor_1;
    assign sensor_vec[2] = i_sensor_2;
    assign sensor_vec[3] = i_sensor_3;
    assign sensor_vec[4] = i_sensor_4;
    assign sensor_vec[5] = i_sensor_5;
    assign sensor_vec[6] = i_sensor_6;
    assign sensor_vec[7] = i_sensor_7;

    bwm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // stages 1-2: weighted sums, total, peak
    bwm_sum u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_accept),
        .i_sensor (sensor_vec),
        .i_cmd_l  (i_left_command),
        .i_cmd_r  (i_right_command),
        .o_beat   (sum_beat)
    );

    // stages 3-5: divide by 350, slow-down, bias and command mix
    bwm_adjust u_adjust (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (sum_beat),
        .i_cfg   (cfg),
        .o_beat  (mix_beat)
    );

    // stage 6: saturation and output register
    bwm_sat u_sat (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (mix_beat),
        .i_speed_limit (cfg.speed_limit),
        .o_valid       (o_valid),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed)
    );

endmodule

// File: rtl/bwm_cfg.sv
// Configuration register file: speed limit, wheel biases, activity threshold.
module bwm_cfg
    import bwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_LIMIT: n_cfg.speed_limit        = i_cfg_data[LIMIT_W-1:0];
                CFG_LEFT_BIAS:   n_cfg.left_bias          = i_cfg_data[BIAS_W-1:0];
                CFG_RIGHT_BIAS:  n_cfg.right_bias         = i_cfg_data[BIAS_W-1:0];
                CFG_ACT_THRESH:  n_cfg.activity_threshold = i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit        <= SPEED_LIMIT_RST;
            r_cfg.left_bias          <= LEFT_BIAS_RST;
            r_cfg.right_bias         <= RIGHT_BIAS_RST;
            r_cfg.activity_threshold <= ACT_THRESH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/bwm_sum.sv
// Two-stage reduction: weighted sums, reading total and peak reading.
module bwm_sum
    import bwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_sensor_vec             i_sensor,
    input  logic signed [CMD_W-1:0] i_cmd_l,
    input  logic signed [CMD_W-1:0] i_cmd_r,
    output t_sum_beat               o_beat
);

    // stage 1: pair terms
    logic                      r_s1_valid;
    logic signed [SUM_W-1:0]   r_s1_pl  [PAIR_COUNT];
    logic signed [SUM_W-1:0]   r_s1_pr  [PAIR_COUNT];
    logic [PAIR_TOT_W-1:0]     r_s1_tot [PAIR_COUNT];
    logic [SENSOR_W-1:0]       r_s1_max [PAIR_COUNT];
    logic signed [CMD_W-1:0]   r_s1_cmd_l;
    logic signed [CMD_W-1:0]   r_s1_cmd_r;

    logic signed [SUM_W-1:0]   n_s1_pl  [PAIR_COUNT];
    logic signed [SUM_W-1:0]   n_s1_pr  [PAIR_COUNT];
    logic [PAIR_TOT_W-1:0]     n_s1_tot [PAIR_COUNT];
    logic [SENSOR_W-1:0]       n_s1_max [PAIR_COUNT];

    // stage 2: full reduction
    logic                      r_s2_valid;
    logic signed [SUM_W-1:0]   r_s2_sum_l;
    logic signed [SUM_W-1:0]   r_s2_sum_r;
    logic [TOTAL_W-1:0]        r_s2_total;
    logic [SENSOR_W-1:0]       r_s2_peak;
    logic signed [CMD_W-1:0]   r_s2_cmd_l;
    logic signed [CMD_W-1:0]   r_s2_cmd_r;

    logic signed [SUM_W-1:0]   n_s2_sum_l;
    logic signed [SUM_W-1:0]   n_s2_sum_r;
    logic [TOTAL_W-1:0]        n_s2_total;
    logic [SENSOR_W-1:0]       n_s2_peak;

    always_comb begin
        for (int j = 0; j < PAIR_COUNT; j++) begin
            n_s1_pl[j]  = weight_term(i_sensor[2*j],   W_LEFT[2*j])
                        + weight_term(i_sensor[2*j+1], W_LEFT[2*j+1]);
            n_s1_pr[j]  = weight_term(i_sensor[2*j],   W_RIGHT[2*j])
                        + weight_term(i_sensor[2*j+1], W_RIGHT[2*j+1]);
            n_s1_tot[j] = PAIR_TOT_W'(i_sensor[2*j]) + PAIR_TOT_W'(i_sensor[2*j+1]);
            n_s1_max[j] = (i_sensor[2*j] > i_sensor[2*j+1]) ? i_sensor[2*j]
                                                             : i_sensor[2*j+1];
        end
    end

    always_comb begin
        n_s2_sum_l = '0;
        n_s2_sum_r = '0;
        n_s2_total = '0;
        n_s2_peak  = '0;
        for (int j = 0; j < PAIR_COUNT; j++) begin
            n_s2_sum_l = n_s2_sum_l + r_s1_pl[j];
            n_s2_sum_r = n_s2_sum_r + r_s1_pr[j];
            n_s2_total = n_s2_total + TOTAL_W'(r_s1_tot[j]);
            if (r_s1_max[j] > n_s2_peak) begin
                n_s2_peak = r_s1_max[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pl    <= n_s1_pl;
        r_s1_pr    <= n_s1_pr;
        r_s1_tot   <= n_s1_tot;
        r_s1_max   <= n_s1_max;
        r_s1_cmd_l <= i_cmd_l;
        r_s1_cmd_r <= i_cmd_r;
        r_s2_sum_l <= n_s2_sum_l;
        r_s2_sum_r <= n_s2_sum_r;
        r_s2_total <= n_s2_total;
        r_s2_peak  <= n_s2_peak;
        r_s2_cmd_l <= r_s1_cmd_l;
        r_s2_cmd_r <= r_s1_cmd_r;
    end

    always_comb begin
        o_beat.valid = r_s2_valid;
        o_beat.sum_l = r_s2_sum_l;
        o_beat.sum_r = r_s2_sum_r;
        o_beat.total = r_s2_total;
        o_beat.peak  = r_s2_peak;
        o_beat.cmd_l = r_s2_cmd_l;
        o_beat.cmd_r = r_s2_cmd_r;
    end

`ifndef SYNTHESIS
    // peak reading can never exceed the sum of all readings
    a_peak_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (TOTAL_W'(r_s2_peak) <= r_s2_total))
        else $error("peak reading above reading total");
`endif

endmodule

// File: rtl/bwm_adjust.sv
// Three-stage wheel term: divide by 350, slow-down by peak, add command and bias.
module bwm_adjust
    import bwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sum_beat i_beat,
    input  t_cfg      i_cfg,
    output t_mix_beat o_beat
);

    // stage 3: magnitudes, slow product, threshold compare
    logic                      r_s3_valid;
    logic [ABS_W-1:0]          r_s3_abs  [WHEELS];
    logic                      r_s3_neg  [WHEELS];
    logic signed [PROD_W-1:0]  r_s3_prod [WHEELS];
    logic signed [CMD_W-1:0]   r_s3_cmd  [WHEELS];
    logic                      r_s3_slow;

    logic [ABS_W-1:0]          n_s3_abs  [WHEELS];
    logic                      n_s3_neg  [WHEELS];
    logic signed [PROD_W-1:0]  n_s3_prod [WHEELS];
    logic signed [CMD_W-1:0]   n_s3_cmd  [WHEELS];

    // stage 4: reciprocal quotient, slowed command
    logic                      r_s4_valid;
    logic [QUO_W-1:0]          r_s4_q    [WHEELS];
    logic                      r_s4_neg  [WHEELS];
    logic signed [ADJ_W-1:0]   r_s4_adj  [WHEELS];

    logic [QUO_W-1:0]          n_s4_q    [WHEELS];
    logic signed [ADJ_W-1:0]   n_s4_adj  [WHEELS];

    // stage 5: signed mix
    logic                      r_s5_valid;
    logic signed [MIX_W-1:0]   r_s5_mix  [WHEELS];
    logic signed [MIX_W-1:0]   n_s5_mix  [WHEELS];

    logic signed [SUM_W-1:0]   sum_in    [WHEELS];
    logic signed [BIAS_W-1:0]  bias_in   [WHEELS];

    assign sum_in[0]  = i_beat.sum_l;
    assign sum_in[1]  = i_beat.sum_r;
    assign n_s3_cmd[0] = i_beat.cmd_l;
    assign n_s3_cmd[1] = i_beat.cmd_r;
    assign bias_in[0] = i_cfg.left_bias;
    assign bias_in[1] = i_cfg.right_bias;

    always_comb begin
        logic signed [SUM_W-1:0]  mag;
        logic signed [PROD_W-1:0] cmd_x;
        logic signed [PROD_W-1:0] peak_x;
        for (int w = 0; w < WHEELS; w++) begin
            n_s3_neg[w]  = sum_in[w][SUM_W-1];
            mag          = n_s3_neg[w] ? -sum_in[w] : sum_in[w];
            n_s3_abs[w]  = mag[ABS_W-1:0];
            cmd_x        = n_s3_cmd[w];
            peak_x       = PROD_W'(i_beat.peak);
            n_s3_prod[w] = cmd_x * peak_x;
        end
    end

    always_comb begin
        logic [ABS_W+RECIP_W-1:0] full;
        logic signed [PROD_W-1:0] round_add;
        logic signed [PROD_W-1:0] shifted;
        logic signed [ADJ_W-1:0]  cmd_w;
        logic signed [ADJ_W-1:0]  trim_w;
        for (int w = 0; w < WHEELS; w++) begin
            full      = (ABS_W+RECIP_W)'(r_s3_abs[w]) * (ABS_W+RECIP_W)'(RECIP);
            n_s4_q[w] = full[RECIP_SHIFT +: QUO_W];
            // truncate toward zero: bias negative products before the shift
            round_add = r_s3_prod[w][PROD_W-1] ? PROD_W'(SLOW_ROUND) : PROD_W'(0);
            shifted   = (r_s3_prod[w] + round_add) >>> SLOW_SHIFT;
            cmd_w     = ADJ_W'(r_s3_cmd[w]);
            trim_w    = ADJ_W'(shifted);
            n_s4_adj[w] = r_s3_slow ? (cmd_w - trim_w) : cmd_w;
        end
    end

    always_comb begin
        logic signed [MIX_W-1:0] q_x;
        logic signed [MIX_W-1:0] adj_x;
        logic signed [MIX_W-1:0] bias_x;
        for (int w = 0; w < WHEELS; w++) begin
            q_x    = MIX_W'(r_s4_q[w]);
            adj_x  = r_s4_adj[w];
            bias_x = bias_in[w];
            n_s5_mix[w] = adj_x + (r_s4_neg[w] ? -q_x : q_x) + bias_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_beat.valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_abs  <= n_s3_abs;
        r_s3_neg  <= n_s3_neg;
        r_s3_prod <= n_s3_prod;
        r_s3_cmd  <= n_s3_cmd;
        r_s3_slow <= (i_beat.total > i_cfg.activity_threshold);
        r_s4_q    <= n_s4_q;
        r_s4_neg  <= r_s3_neg;
        r_s4_adj  <= n_s4_adj;
        r_s5_mix  <= n_s5_mix;
    end

    always_comb begin
        o_beat.valid = r_s5_valid;
        o_beat.mix_l = r_s5_mix[0];
        o_beat.mix_r = r_s5_mix[1];
    end

`ifndef SYNTHESIS
    // at or below the threshold the command passes unchanged
    a_no_slow_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !r_s3_slow) |=>
            (r_s4_adj[0] == ADJ_W'($past(r_s3_cmd[0]))) &&
            (r_s4_adj[1] == ADJ_W'($past(r_s3_cmd[1]))))
        else $error("command altered without slow-down");

    // reciprocal quotient stays within the reachable range
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_s4_q[0] <= QUO_W'(QUO_MAX)) && (r_s4_q[1] <= QUO_W'(QUO_MAX)))
        else $error("obstacle quotient out of range");
`endif

endmodule

// File: rtl/bwm_sat.sv
// Output stage: symmetric saturation to the speed limit, result strobe.
module bwm_sat
    import bwm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mix_beat                 i_beat,
    input  logic [LIMIT_W-1:0]        i_speed_limit,
    output logic                      o_valid,
    output logic signed [SPEED_W-1:0] o_left_speed,
    output logic signed [SPEED_W-1:0] o_right_speed
);

    logic                      r_valid;
    logic signed [SPEED_W-1:0] r_speed [WHEELS];
    logic signed [SPEED_W-1:0] n_speed [WHEELS];
    logic signed [MIX_W-1:0]   mix_in  [WHEELS];

    assign mix_in[0] = i_beat.mix_l;
    assign mix_in[1] = i_beat.mix_r;

    always_comb begin
        logic signed [MIX_W-1:0] lim_x;
        logic signed [MIX_W-1:0] res;
        lim_x = MIX_W'(i_speed_limit);
        for (int w = 0; w < WHEELS; w++) begin
            if (mix_in[w] > lim_x) begin
                res = lim_x;
            end else if (mix_in[w] < -lim_x) begin
                res = -lim_x;
            end else begin
                res = mix_in[w];
            end
            n_speed[w] = SPEED_W'(res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_speed <= n_speed;
    end

    assign o_valid       = r_valid;
    assign o_left_speed  = r_speed[0];
    assign o_right_speed = r_speed[1];

`ifndef SYNTHESIS
    logic signed [SPEED_W-1:0] lim_s;
    assign lim_s = SPEED_W'(i_speed_limit);

    // with the limit steady, both speeds lie inside the band
    a_speed_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $stable(i_speed_limit)) |->
            (o_left_speed  <= lim_s) && (o_left_speed  >= -lim_s) &&
            (o_right_speed <= lim_s) && (o_right_speed >= -lim_s))
        else $error("wheel speed outside speed limit");
`endif

endmodule
